// ----- src/tpaq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpaq_pkg
// Shared types, constants and tables for the phase/amplitude quantizer.
// ----------------------------------------------------------------------------
package tpaq_pkg;

    localparam int TRANSDUCERS_DEF  = 256;
    localparam int PHASE_LEVELS_DEF = 128;

    // word kinds carried on tuser
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    localparam int IDX_W    = 8;
    localparam int TURN_W   = 16;
    localparam int AMP_W    = 16;
    localparam int DEG_W    = 10;
    localparam int PIN_W    = 8;
    localparam int PBYTE_W  = 8;
    localparam int LVL_W    = 7;
    localparam int SHIFT_W  = 6;
    localparam int FINE_W   = 7;
    localparam int SEARCH_W = 6;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    localparam int FINE_STEPS = 64;
    localparam int FINE_SHIFT = 6;

    // degrees -> 1/65536 turn: (mag * 8192 + 22) / 45, via exact reciprocal
    localparam int          DEG_NUM_W   = 23;
    localparam int          RECIP_W     = 24;
    localparam logic [23:0] RECIP_45    = 24'd11930465;
    localparam int          RECIP_SHIFT = 29;
    localparam logic [22:0] DEG_ROUND   = 23'd22;

    // ceil(32768 * sin(k*pi/128)), k = 1..64
    localparam logic [15:0] ASIN_EDGE [0:63] = '{
        16'd805,   16'd1608,  16'd2411,  16'd3212,  16'd4012,  16'd4809,  16'd5603,  16'd6393,
        16'd7180,  16'd7962,  16'd8740,  16'd9513,  16'd10279, 16'd11040, 16'd11794, 16'd12540,
        16'd13279, 16'd14011, 16'd14733, 16'd15447, 16'd16152, 16'd16847, 16'd17531, 16'd18205,
        16'd18869, 16'd19520, 16'd20160, 16'd20788, 16'd21404, 16'd22006, 16'd22595, 16'd23171,
        16'd23733, 16'd24282, 16'd24813, 16'd25331, 16'd25833, 16'd26320, 16'd26791, 16'd27246,
        16'd27685, 16'd28107, 16'd28512, 16'd28899, 16'd29270, 16'd29622, 16'd29957, 16'd30274,
        16'd30573, 16'd30853, 16'd31115, 16'd31358, 16'd31582, 16'd31786, 16'd31972, 16'd32139,
        16'd32286, 16'd32414, 16'd32522, 16'd32611, 16'd32680, 16'd32729, 16'd32759, 16'd32768
    };

    localparam logic [15:0] AMP_ONE = 16'd32768;

    typedef struct packed {
        logic [LVL_W-1:0]   level;
        logic [SHIFT_W-1:0] shift;
    } t_amp_res;

endpackage

// ----- src/tpaq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpaq_ram
// Single-port RAM, registered read. A write leaves the read data untouched.
// ----------------------------------------------------------------------------
module tpaq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tpaq_deg2turn.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpaq_deg2turn
// Signed degree offset to unsigned 16-bit fraction of a turn, rounded.
// ----------------------------------------------------------------------------
module tpaq_deg2turn (
    input  logic [tpaq_pkg::DEG_W-1:0]  i_deg,
    output logic [tpaq_pkg::TURN_W-1:0] o_turn
);

    localparam int PROD_W = tpaq_pkg::DEG_NUM_W + tpaq_pkg::RECIP_W;

    logic                               neg;
    logic [tpaq_pkg::DEG_W-1:0]         mag;
    logic [tpaq_pkg::DEG_NUM_W-1:0]     num;
    logic [PROD_W-1:0]                  prod;
    logic [tpaq_pkg::TURN_W-1:0]        q;

    assign neg  = i_deg[tpaq_pkg::DEG_W-1];
    assign mag  = neg ? (~i_deg + 1'b1) : i_deg;
    assign num  = {mag, 13'b0} + tpaq_pkg::DEG_ROUND;
    // floor(num / 45), exact for num < 2^23
    assign prod = PROD_W'(num) * PROD_W'(tpaq_pkg::RECIP_45);
    assign q    = prod[tpaq_pkg::RECIP_SHIFT +: tpaq_pkg::TURN_W];
    assign o_turn = neg ? (~q + 1'b1) : q;

endmodule

// ----- src/tpaq_amp_lvl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpaq_amp_lvl
// Amplitude to arcsine level and half-missing-amplitude phase shift.
// ----------------------------------------------------------------------------
module tpaq_amp_lvl #(
    parameter int PHASE_LEVELS = tpaq_pkg::PHASE_LEVELS_DEF
) (
    input  logic [tpaq_pkg::AMP_W-1:0] i_amp,
    output tpaq_pkg::t_amp_res         o_res
);

    localparam int PROD_W = 13;
    localparam logic [PROD_W-1:0]          HALF_P = PROD_W'(PHASE_LEVELS / 2);
    localparam logic [tpaq_pkg::LVL_W-1:0] HALF_L = tpaq_pkg::LVL_W'(PHASE_LEVELS / 2);

    logic [tpaq_pkg::AMP_W-1:0]    amp_sat;
    logic [tpaq_pkg::SEARCH_W-1:0] cnt;
    logic [tpaq_pkg::SEARCH_W-1:0] cand;
    logic [tpaq_pkg::FINE_W-1:0]   fine;
    logic [PROD_W-1:0]             lvl_prod;
    logic [tpaq_pkg::LVL_W-1:0]    lvl;

    assign amp_sat = (i_amp > tpaq_pkg::AMP_ONE) ? tpaq_pkg::AMP_ONE : i_amp;

    // edges ascend: count of passed edges by binary search
    always_comb begin
        cnt  = '0;
        cand = '0;
        for (int b = tpaq_pkg::SEARCH_W - 1; b >= 0; b--) begin
            cand = cnt | (tpaq_pkg::SEARCH_W'(1) << b);
            if (amp_sat >= tpaq_pkg::ASIN_EDGE[cand - 1'b1]) begin
                cnt = cand;
            end
        end
        if (amp_sat >= tpaq_pkg::ASIN_EDGE[tpaq_pkg::FINE_STEPS-1]) begin
            fine = tpaq_pkg::FINE_W'(tpaq_pkg::FINE_STEPS);
        end else begin
            fine = {1'b0, cnt};
        end
    end

    assign lvl_prod    = PROD_W'(fine) * HALF_P;
    assign lvl         = tpaq_pkg::LVL_W'(lvl_prod >> tpaq_pkg::FINE_SHIFT);
    assign o_res.level = lvl;
    assign o_res.shift = tpaq_pkg::SHIFT_W'((HALF_L - lvl) >> 1);

endmodule

// ----- src/transducer_phase_amplitude_quantizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transducer_phase_amplitude_quantizer_top
// Phased-array phase/amplitude quantizer with per-transducer calibration.
//
// Input stream: tuser = mode (0 load, 1 convert). Load words store the
// offset (degrees, turned into 1/65536 turn) and pin for one transducer
// and produce nothing. Convert words produce one output word holding the
// pin, the phase byte (bit 7 set for pin 0) and the amplitude level.
// Words with transducer >= TRANSDUCERS are dropped.
// Pipeline: input register, calibration RAM read, output register.
// Output valid rises once a word has passed the input register, RAM read
// and output register. One word per cycle sustained while the receiver
// does not stall, set by the single-port calibration RAM (one access per
// word). A load may be followed at once by a convert of the same
// transducer. When the receiver stalls, empty stages still fill, so up to
// three convert words are taken before s_axis_tready drops.
// Reset clears the pipeline valids only; calibration is undefined until
// loaded, and converting an unloaded transducer yields undefined data.
// ----------------------------------------------------------------------------
module transducer_phase_amplitude_quantizer_top #(
    parameter int TRANSDUCERS  = tpaq_pkg::TRANSDUCERS_DEF,
    parameter int PHASE_LEVELS = tpaq_pkg::PHASE_LEVELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // transducer[7:0], phase_turns[23:8], amplitude[39:24],
    // offset_degrees[49:40], pin[57:50], zero[63:58]
    input  logic [tpaq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pin_index[7:0], phase_byte[15:8], amplitude_level[22:16], zero[23]
    output logic [tpaq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int AW   = (TRANSDUCERS > 1) ? $clog2(TRANSDUCERS) : 1;
    localparam int PL_W = 8;
    localparam int MUL_W = tpaq_pkg::TURN_W + PL_W;
    localparam logic [PL_W-1:0]  PL_N   = PL_W'(PHASE_LEVELS);
    localparam logic [MUL_W-1:0] PL_MUL = MUL_W'(PHASE_LEVELS);

    // stage 1: input register
    logic                          r_s1_valid;
    logic                          r_s1_mode;
    logic [tpaq_pkg::IDX_W-1:0]    r_s1_idx;
    logic [tpaq_pkg::TURN_W-1:0]   r_s1_phase;
    logic [tpaq_pkg::AMP_W-1:0]    r_s1_amp;
    logic [tpaq_pkg::DEG_W-1:0]    r_s1_deg;
    logic [tpaq_pkg::PIN_W-1:0]    r_s1_pin;

    // stage 2: RAM data aligned
    logic                          r_s2_valid;
    logic [tpaq_pkg::TURN_W-1:0]   r_s2_phase;
    tpaq_pkg::t_amp_res            r_s2_amp;

    // stage 3: output register
    logic                          r_s3_valid;
    logic [tpaq_pkg::PIN_W-1:0]    r_s3_pin;
    logic [tpaq_pkg::PBYTE_W-1:0]  r_s3_phase;
    logic [tpaq_pkg::LVL_W-1:0]    r_s3_lvl;

    logic                          adv3;
    logic                          rdy2;
    logic                          in_range1;
    logic                          conv1;
    logic                          load1;
    logic                          pass1;
    logic                          ram_en;
    logic [AW-1:0]                 ram_addr;
    logic [tpaq_pkg::TURN_W-1:0]   off_wdata;
    logic [tpaq_pkg::TURN_W-1:0]   off_rdata;
    logic [tpaq_pkg::PIN_W-1:0]    pin_rdata;
    tpaq_pkg::t_amp_res            amp1;

    logic [tpaq_pkg::TURN_W-1:0]   diff2;
    logic [MUL_W-1:0]              prod2;
    logic [PL_W-1:0]               sum2;
    logic [PL_W-1:0]               wrap2;
    logic [tpaq_pkg::PBYTE_W-1:0]  n_phase;

    // handshake chain
    assign adv3      = !r_s3_valid || m_axis_tready;
    assign rdy2      = !r_s2_valid || adv3;
    assign in_range1 = {1'b0, r_s1_idx} < (tpaq_pkg::IDX_W + 1)'(TRANSDUCERS);
    assign conv1     = r_s1_valid && (r_s1_mode == tpaq_pkg::MODE_CONVERT) && in_range1;
    assign load1     = r_s1_valid && (r_s1_mode == tpaq_pkg::MODE_LOAD) && in_range1;
    assign pass1     = !conv1 || rdy2;
    assign s_axis_tready = pass1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pass1) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && pass1) begin
            r_s1_mode  <= s_axis_tuser;
            r_s1_idx   <= s_axis_tdata[7:0];
            r_s1_phase <= s_axis_tdata[23:8];
            r_s1_amp   <= s_axis_tdata[39:24];
            r_s1_deg   <= s_axis_tdata[49:40];
            r_s1_pin   <= s_axis_tdata[57:50];
        end
    end

    tpaq_deg2turn u_deg2turn (
        .i_deg  (r_s1_deg),
        .o_turn (off_wdata)
    );

    tpaq_amp_lvl #(
        .PHASE_LEVELS (PHASE_LEVELS)
    ) u_amp_lvl (
        .i_amp (r_s1_amp),
        .o_res (amp1)
    );

    assign ram_en   = load1 || (conv1 && rdy2);
    assign ram_addr = r_s1_idx[AW-1:0];

    tpaq_ram #(
        .WIDTH (tpaq_pkg::TURN_W),
        .DEPTH (TRANSDUCERS)
    ) u_off_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (load1),
        .i_addr  (ram_addr),
        .i_wdata (off_wdata),
        .o_rdata (off_rdata)
    );

    tpaq_ram #(
        .WIDTH (tpaq_pkg::PIN_W),
        .DEPTH (TRANSDUCERS)
    ) u_pin_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (load1),
        .i_addr  (ram_addr),
        .i_wdata (r_s1_pin),
        .o_rdata (pin_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= conv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv1 && rdy2) begin
            r_s2_phase <= r_s1_phase;
            r_s2_amp   <= amp1;
        end
    end

    // phase level, amplitude shift, wrap
    assign diff2 = r_s2_phase - off_rdata;
    assign prod2 = MUL_W'(diff2) * PL_MUL;
    assign sum2  = PL_W'(prod2[MUL_W-1:tpaq_pkg::TURN_W]) + PL_W'(r_s2_amp.shift);
    assign wrap2 = (sum2 >= PL_N) ? (sum2 - PL_N) : sum2;
    assign n_phase = {(pin_rdata == '0), wrap2[tpaq_pkg::PBYTE_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && adv3) begin
            r_s3_pin   <= pin_rdata;
            r_s3_phase <= n_phase;
            r_s3_lvl   <= r_s2_amp.level;
        end
    end

    assign m_axis_tvalid = r_s3_valid;
    assign m_axis_tdata  = {1'b0, r_s3_lvl, r_s3_phase, r_s3_pin};

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (r_s3_lvl <= tpaq_pkg::LVL_W'(PHASE_LEVELS / 2)))
        else $error("amplitude level above half scale");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> ({1'b0, r_s3_phase[tpaq_pkg::PBYTE_W-2:0]} < PL_N))
        else $error("phase level out of range");

    a_pin0_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (r_s3_phase[tpaq_pkg::PBYTE_W-1] == (r_s3_pin == '0)))
        else $error("pin zero flag mismatch");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !adv3) |=> r_s2_valid)
        else $error("stage 2 word lost under stall");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_s2_valid && r_s3_valid))
        else $error("input stalled with an empty stage");

endmodule
